[sv/res_pkg.sv]
// ----------------------------------------------------------------------------
// res_pkg
// Shared constants, payload types and state encodings for the relative
// error statistics block.
// ----------------------------------------------------------------------------
package res_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SUM_BITS    = 48;
    localparam int QUEUE_DEPTH = 2;
    localparam int DATA_W      = 32;
    localparam int ERR_W       = 31;
    localparam int ADDR_W      = 3;

    localparam logic [ERR_W-1:0]    ERR_MAX     = {ERR_W{1'b1}};
    localparam logic [ERR_W-1:0]    FLOOR_RESET = ERR_W'(1);
    localparam logic [SUM_BITS-1:0] SUM_MAX     = {SUM_BITS{1'b1}};

    // register index, taken from paddr[2]
    localparam logic REG_FLOOR = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured;
        logic signed [DATA_W-1:0] reference;
        logic                     last_item;
    } res_item_t;

    typedef struct packed {
        logic [ERR_W-1:0]    max_error;
        logic [ERR_W-1:0]    min_error;
        logic [SUM_BITS-1:0] error_sum;
        logic                sum_saturated;
    } res_result_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIVIDE,
        BACK_UPDATE
    } back_state_t;

endpackage

[sv/res_front.sv]
// ----------------------------------------------------------------------------
// res_front
// Classifies a request: a reference below the floor, or not positive, takes
// the absolute-value path; any other gets a scaled difference for division.
// ----------------------------------------------------------------------------
module res_front #(
    parameter  int FRAC_BITS = res_pkg::FRAC_BITS,
    localparam int NUM_W     = FRAC_BITS + res_pkg::DATA_W + 1,
    localparam int ENTRY_W   = NUM_W + res_pkg::ERR_W + 2
) (
    input  res_pkg::res_item_t               item,
    input  logic [res_pkg::ERR_W-1:0]        floor_val,
    output logic [ENTRY_W-1:0]               entry
);

    localparam int DW = res_pkg::DATA_W;
    localparam int EW = res_pkg::ERR_W;

    logic [DW:0]    diff_s;
    logic [DW:0]    diff_mag;
    logic [DW-1:0]  m_neg;
    logic [EW-1:0]  m_abs;
    logic           direct;
    logic [NUM_W-1:0] num;

    always_comb
    begin
        diff_s   = {item.measured[DW-1], item.measured}
                 - {item.reference[DW-1], item.reference};
        diff_mag = diff_s[DW] ? (~diff_s + (DW+1)'(1)) : diff_s;

        m_neg = ~item.measured + DW'(1);
        if (!item.measured[DW-1])
            m_abs = item.measured[EW-1:0];
        else if (m_neg[DW-1])
            m_abs = res_pkg::ERR_MAX;
        else
            m_abs = m_neg[EW-1:0];

        direct = item.reference[DW-1]
              || (item.reference[EW-1:0] < floor_val)
              || (item.reference == '0);

        num = direct ? {{(NUM_W-EW){1'b0}}, m_abs}
                     : {diff_mag, {FRAC_BITS{1'b0}}};

        entry = {item.last_item, direct, num, item.reference[EW-1:0]};
    end

endmodule

[sv/res_queue.sv]
// ----------------------------------------------------------------------------
// res_queue
// Short first-in first-out queue between the classifier and the divider.
// ----------------------------------------------------------------------------
module res_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = res_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] data_out,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= data_in;
    end

endmodule

[sv/res_back.sv]
// ----------------------------------------------------------------------------
// res_back
// Restoring divider, one quotient bit per cycle, followed by the running
// maximum, minimum and saturating sum, and the result register.
// ----------------------------------------------------------------------------
module res_back #(
    parameter  int FRAC_BITS = res_pkg::FRAC_BITS,
    localparam int NUM_W     = FRAC_BITS + res_pkg::DATA_W + 1,
    localparam int ENTRY_W   = NUM_W + res_pkg::ERR_W + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  logic [ENTRY_W-1:0]   q_data,
    output logic                 q_pop,
    output res_pkg::res_result_t result,
    output logic                 empty,
    input  logic                 pop
);

    localparam int EW    = res_pkg::ERR_W;
    localparam int SW    = res_pkg::SUM_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    res_pkg::back_state_t state_reg, state_next;

    logic [NUM_W-1:0] num_reg;
    logic [EW-1:0]    div_reg;
    logic [EW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             last_reg;

    logic [EW-1:0]    max_reg, max_next;
    logic [EW-1:0]    min_reg, min_next;
    logic [SW-1:0]    sum_reg, sum_next;
    logic             clip_reg, clip_next;
    logic             out_valid_reg;
    res_pkg::res_result_t result_reg;

    logic             e_last;
    logic             e_direct;
    logic [NUM_W-1:0] e_num;
    logic [EW-1:0]    e_div;
    logic [EW:0]      trial;
    logic [EW:0]      trial_diff;
    logic             fits;
    logic [EW-1:0]    err;
    logic [SW:0]      sum_ext;
    logic             slot_free;
    logic             div_step;
    logic             stat_upd;
    logic             res_load;

    assign {e_last, e_direct, e_num, e_div} = q_data;
    assign empty     = !out_valid_reg;
    assign result    = result_reg;
    assign slot_free = !out_valid_reg || pop;

    // divider step and error forming
    always_comb
    begin
        trial      = {rem_reg, num_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, div_reg};
        fits       = (trial >= {1'b0, div_reg});
        rem_next   = fits ? trial_diff[EW-1:0] : trial[EW-1:0];
        err        = (|num_reg[NUM_W-1:EW]) ? res_pkg::ERR_MAX : num_reg[EW-1:0];
    end

    // statistics update
    always_comb
    begin
        max_next = (err > max_reg) ? err : max_reg;
        min_next = (err < min_reg) ? err : min_reg;
        sum_ext  = {1'b0, sum_reg} + {{(SW+1-EW){1'b0}}, err};
        if (sum_ext >= {1'b0, res_pkg::SUM_MAX})
        begin
            sum_next  = res_pkg::SUM_MAX;
            clip_next = 1'b1;
        end
        else
        begin
            sum_next  = sum_ext[SW-1:0];
            clip_next = clip_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            res_pkg::BACK_IDLE:
            begin
                if (!q_empty)
                    state_next = e_direct ? res_pkg::BACK_UPDATE : res_pkg::BACK_DIVIDE;
            end
            res_pkg::BACK_DIVIDE:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = res_pkg::BACK_UPDATE;
            end
            res_pkg::BACK_UPDATE:
            begin
                if (!last_reg || slot_free)
                    state_next = res_pkg::BACK_IDLE;
            end
            default:
                state_next = res_pkg::BACK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        div_step = 1'b0;
        stat_upd = 1'b0;
        unique case (state_reg)
            res_pkg::BACK_IDLE:   q_pop    = !q_empty;
            res_pkg::BACK_DIVIDE: div_step = 1'b1;
            res_pkg::BACK_UPDATE: stat_upd = !last_reg || slot_free;
            default:              q_pop    = 1'b0;
        endcase
        res_load = stat_upd && last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= res_pkg::BACK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            num_reg  <= e_num;
            div_reg  <= e_div;
            rem_reg  <= '0;
            last_reg <= e_last;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= '0;
            min_reg  <= res_pkg::ERR_MAX;
            sum_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else if (res_load)
        begin
            max_reg  <= '0;
            min_reg  <= res_pkg::ERR_MAX;
            sum_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else if (stat_upd)
        begin
            max_reg  <= max_next;
            min_reg  <= min_next;
            sum_reg  <= sum_next;
            clip_reg <= clip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg.max_error     <= max_next;
            result_reg.min_error     <= min_next;
            result_reg.error_sum     <= sum_next;
            result_reg.sum_saturated <= clip_next;
        end
    end

`ifndef SYNTH
    a_divide_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == res_pkg::BACK_DIVIDE |-> cnt_reg != '0)
        else $error("divider running with zero step count");

    a_clip_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
        clip_reg |-> sum_reg == res_pkg::SUM_MAX)
        else $error("sum flagged saturated but not at maximum");

    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == res_pkg::BACK_DIVIDE || state_reg == res_pkg::BACK_UPDATE))
        else $error("queue popped without starting work");

    a_plain_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == res_pkg::BACK_UPDATE && !last_reg |=> state_reg == res_pkg::BACK_IDLE)
        else $error("non-final update stalled");
`endif

endmodule

[sv/relative_error_stats_top.sv]
// ----------------------------------------------------------------------------
// relative_error_stats_top
// Relative error statistics over sets of (measured, reference) Q16.16 pairs.
// A request whose reference is below the floor register (or not positive)
// skips the divider and goes straight to the statistics update in the back
// end; any other request passes through the restoring divider, which retires
// one quotient bit per cycle over a FRAC_BITS + 33 bit dividend. Up to
// QUEUE_DEPTH classified requests wait ahead of the divider, and one result
// waits in the output register without holding up the divider until the
// next final request of a set needs that register.
// ----------------------------------------------------------------------------
module relative_error_stats_top #(
    parameter int FRAC_BITS   = res_pkg::FRAC_BITS,
    parameter int QUEUE_DEPTH = res_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  res_pkg::res_item_t           item,
    output logic                         full,
    output logic                         empty,
    input  logic                         pop,
    output res_pkg::res_result_t         result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [res_pkg::ADDR_W-1:0]   paddr,
    input  logic [res_pkg::DATA_W-1:0]   pwdata,
    output logic [res_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int NUM_W   = FRAC_BITS + res_pkg::DATA_W + 1;
    localparam int ENTRY_W = NUM_W + res_pkg::ERR_W + 2;

    logic [res_pkg::ERR_W-1:0] floor_reg;
    logic [ENTRY_W-1:0]        entry;
    logic [ENTRY_W-1:0]        q_data;
    logic                      q_empty;
    logic                      q_pop;
    logic                      floor_sel;

    assign pready    = 1'b1;
    assign floor_sel = (paddr[2] == res_pkg::REG_FLOOR);
    assign prdata    = floor_sel ? {1'b0, floor_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            floor_reg <= res_pkg::FLOOR_RESET;
        else if (psel && penable && pwrite && pready && floor_sel)
            floor_reg <= pwdata[res_pkg::ERR_W-1:0];
    end

    res_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .item      (item),
        .floor_val (floor_reg),
        .entry     (entry)
    );

    res_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (entry),
        .full     (full),
        .pop      (q_pop),
        .data_out (q_data),
        .empty    (q_empty)
    );

    res_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
